// ----- rtl/pcx_pkg.sv -----
// Shared constants and types for the PCX run-length decoder.
`timescale 1ns / 1ps

package pcx_pkg;

    localparam int DEFAULT_MAX_DIMENSION = 4096;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;
    localparam int CFG_W  = 13;
    localparam int POS_W  = 12;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [1:0] RUN_TAG = 2'b11;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WRAP,
        ST_END
    } state_t;

    typedef struct packed {
        logic clear;
        logic step_col;
        logic wrap_row;
    } pos_cmd_t;

    typedef struct packed {
        logic col_lt_w;
        logic col_last;
        logic row_last;
        logic row_ge_h;
    } pos_flags_t;

endpackage

// ----- rtl/pcx_apb_regs.sv -----
// APB register block holding the image width and height, with clamped outputs.
`timescale 1ns / 1ps

module pcx_apb_regs #(
    parameter int MAX_DIMENSION = pcx_pkg::DEFAULT_MAX_DIMENSION,
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcx_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcx_pkg::DATA_W-1:0]  pwdata,
    output logic [pcx_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [DIM_W-1:0]            dim_w,
    output logic [DIM_W-1:0]            dim_h
);
    import pcx_pkg::*;

    localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_next;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] height_next;
    logic             wr_en;
    logic             reg_sel;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        logic [CMP_W-1:0] lim;
        ext = CMP_W'(v);
        lim = CMP_W'(MAX_DIMENSION);
        if (v == '0)
        begin
            ext = CMP_W'(1);
        end
        else if (ext > lim)
        begin
            ext = lim;
        end
        return ext[DIM_W-1:0];
    endfunction

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[ADDR_W-1];
    assign pready  = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign dim_w = clamp_dim(width_reg);
    assign dim_h = clamp_dim(height_reg);

endmodule

// ----- rtl/pcx_pos_unit.sv -----
// Column and row position registers with one shared incrementer and compares.
`timescale 1ns / 1ps

module pcx_pos_unit #(
    parameter int MAX_DIMENSION = pcx_pkg::DEFAULT_MAX_DIMENSION,
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcx_pkg::pos_cmd_t   cmd,
    input  logic [DIM_W-1:0]    dim_w,
    input  logic [DIM_W-1:0]    dim_h,
    output logic [DIM_W-1:0]    col,
    output logic [DIM_W-1:0]    row,
    output pcx_pkg::pos_flags_t flags
);
    import pcx_pkg::*;

    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] row_next;
    logic [DIM_W-1:0] operand;
    logic [DIM_W-1:0] sum;

    assign operand = cmd.wrap_row ? row_reg : col_reg;
    assign sum     = operand + DIM_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.clear)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.wrap_row)
        begin
            col_next = '0;
            row_next = sum;
        end
        else if (cmd.step_col)
        begin
            col_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col            = col_reg;
    assign row            = row_reg;
    assign flags.col_lt_w = col_reg < dim_w;
    assign flags.col_last = col_reg == (dim_w - DIM_W'(1));
    assign flags.row_last = row_reg == (dim_h - DIM_W'(1));
    assign flags.row_ge_h = row_reg >= dim_h;

endmodule

// ----- rtl/pcx_seq.sv -----
// Sequencer that decodes bytes, steps runs one pixel at a time and registers each result word.
`timescale 1ns / 1ps

module pcx_seq #(
    parameter int MAX_DIMENSION = pcx_pkg::DEFAULT_MAX_DIMENSION,
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [pcx_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        end_of_data,
    output logic                        pix_valid,
    input  logic                        pix_stall,
    output logic [pcx_pkg::BYTE_W-1:0]  pixel,
    output logic [pcx_pkg::POS_W-1:0]   column,
    output logic [pcx_pkg::POS_W-1:0]   row,
    output logic                        last_of_item,
    output logic                        image_done,
    output logic                        truncated,
    input  logic [DIM_W-1:0]            pos_col,
    input  logic [DIM_W-1:0]            pos_row,
    input  pcx_pkg::pos_flags_t         flags,
    output pcx_pkg::pos_cmd_t           cmd
);
    import pcx_pkg::*;

    localparam int EXT_W = (DIM_W > POS_W) ? DIM_W : POS_W;

    state_t            state_reg;
    state_t            state_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              eod_reg;
    logic              eod_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  pend_reg;
    logic [CNT_W-1:0]  pend_next;
    logic              await_reg;
    logic              await_next;
    logic              complete_reg;
    logic              complete_next;
    logic              pix_valid_reg;
    logic              pix_valid_next;
    logic [BYTE_W-1:0] pixel_reg;
    logic [BYTE_W-1:0] pixel_next;
    logic [POS_W-1:0]  column_reg;
    logic [POS_W-1:0]  column_next;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  row_next;
    logic              last_reg;
    logic              last_next;
    logic              done_reg;
    logic              done_next;
    logic              trunc_reg;
    logic              trunc_next;

    logic              load_ok;
    logic              complete_in;
    logic              is_hdr;
    logic              have_value;
    logic              last_px;
    logic              px_done;
    logic              run_over;
    logic [EXT_W-1:0]  col_ext;
    logic [EXT_W-1:0]  row_ext;

    assign load_ok     = !pix_valid_reg || !pix_stall;
    assign complete_in = complete_reg || flags.row_ge_h;
    assign is_hdr      = data_byte[BYTE_W-1:BYTE_W-2] == RUN_TAG;
    assign have_value  = !complete_in && (await_reg || !is_hdr);
    assign last_px     = (rem_reg == CNT_W'(1)) || flags.col_last;
    assign px_done     = flags.col_last && flags.row_last;
    assign run_over    = (rem_reg == '0) || !flags.col_lt_w;
    assign col_ext     = EXT_W'(pos_col);
    assign row_ext     = EXT_W'(pos_row);
    assign byte_stall  = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    state_next = have_value ? ST_RUN : ST_END;
                end
            end
            ST_RUN:
            begin
                if (run_over || (load_ok && last_px))
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_END;
            end
            ST_END:
            begin
                if (!(eod_reg && !complete_reg && !load_ok))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        byte_next      = byte_reg;
        eod_next       = eod_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        await_next     = await_reg;
        complete_next  = complete_reg;
        pix_valid_next = pix_valid_reg && pix_stall;
        pixel_next     = pixel_reg;
        column_next    = column_reg;
        row_next       = row_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        trunc_next     = trunc_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    byte_next     = data_byte;
                    eod_next      = end_of_data;
                    complete_next = complete_in;
                    rem_next      = '0;
                    if (!complete_in)
                    begin
                        if (await_reg)
                        begin
                            rem_next   = pend_reg;
                            await_next = 1'b0;
                            pend_next  = '0;
                        end
                        else if (is_hdr)
                        begin
                            pend_next  = data_byte[CNT_W-1:0];
                            await_next = 1'b1;
                        end
                        else
                        begin
                            rem_next = CNT_W'(1);
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (run_over)
                begin
                    rem_next = '0;
                end
                else if (load_ok)
                begin
                    pix_valid_next = 1'b1;
                    pixel_next     = byte_reg;
                    column_next    = col_ext[POS_W-1:0];
                    row_next       = row_ext[POS_W-1:0];
                    last_next      = last_px && !(eod_reg && !px_done);
                    done_next      = px_done;
                    trunc_next     = 1'b0;
                    cmd.step_col   = 1'b1;
                    rem_next       = last_px ? '0 : rem_reg - CNT_W'(1);
                end
            end
            ST_WRAP:
            begin
                if (!flags.col_lt_w)
                begin
                    cmd.wrap_row = 1'b1;
                    if (flags.row_last)
                    begin
                        complete_next = 1'b1;
                    end
                end
            end
            ST_END:
            begin
                if (eod_reg && (complete_reg || load_ok))
                begin
                    if (!complete_reg)
                    begin
                        pix_valid_next = 1'b1;
                        pixel_next     = '0;
                        column_next    = col_ext[POS_W-1:0];
                        row_next       = row_ext[POS_W-1:0];
                        last_next      = 1'b1;
                        done_next      = 1'b0;
                        trunc_next     = 1'b1;
                    end
                    cmd.clear     = 1'b1;
                    await_next    = 1'b0;
                    pend_next     = '0;
                    complete_next = 1'b0;
                end
            end
            default:
            begin
                rem_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            pend_reg      <= '0;
            await_reg     <= 1'b0;
            complete_reg  <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            await_reg     <= await_next;
            complete_reg  <= complete_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        eod_reg    <= eod_next;
        pixel_reg  <= pixel_next;
        column_reg <= column_next;
        row_reg    <= row_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
        trunc_reg  <= trunc_next;
    end

    assign pix_valid    = pix_valid_reg;
    assign pixel        = pixel_reg;
    assign column       = column_reg;
    assign row          = row_reg;
    assign last_of_item = last_reg;
    assign image_done   = done_reg;
    assign truncated    = trunc_reg;

    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && trunc_reg |-> last_reg && !done_reg)
        else $error("Truncated status word is not the final word of its byte.");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && done_reg |-> last_reg)
        else $error("Image completion flagged on a word that is not the last one.");

    a_idle_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> rem_reg == '0)
        else $error("Run count left over when the sequencer returned to idle.");

    a_step_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_col |-> flags.col_lt_w && !complete_reg)
        else $error("Column stepped past the end of the row or after completion.");

endmodule

// ----- rtl/pcx_rle_decoder.sv -----
// Top level of the PCX 8-bit run-length decoder.
//
// Bytes of PCX pixel data enter one at a time and decoded pixels leave one word at a
// time, each tagged with its column and row for the configured width and height (APB
// registers at 0x0 and 0x4, clamped to 1..MAX_DIMENSION). The input is stalled while a
// byte is processed, be it a run header byte, a literal byte, a run value byte or a byte
// ignored after completion, and also while a word waits on a stalled output. The
// sequencer emits at most one pixel per cycle while the output is not stalled, through a
// single shared column and row incrementer. A truncated status word follows when
// end_of_data arrives before the image is complete.
`timescale 1ns / 1ps

module pcx_rle_decoder #(
    parameter int MAX_DIMENSION = pcx_pkg::DEFAULT_MAX_DIMENSION
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcx_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcx_pkg::DATA_W-1:0]  pwdata,
    output logic [pcx_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [pcx_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        end_of_data,
    output logic                        pix_valid,
    input  logic                        pix_stall,
    output logic [pcx_pkg::BYTE_W-1:0]  pixel,
    output logic [pcx_pkg::POS_W-1:0]   column,
    output logic [pcx_pkg::POS_W-1:0]   row,
    output logic                        last_of_item,
    output logic                        image_done,
    output logic                        truncated
);
    import pcx_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;
    logic [DIM_W-1:0] pos_col;
    logic [DIM_W-1:0] pos_row;
    pos_cmd_t         cmd;
    pos_flags_t       flags;

    pcx_apb_regs #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dim_w   (dim_w),
        .dim_h   (dim_h)
    );

    pcx_pos_unit #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .dim_w (dim_w),
        .dim_h (dim_h),
        .col   (pos_col),
        .row   (pos_row),
        .flags (flags)
    );

    pcx_seq #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_data  (end_of_data),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pixel        (pixel),
        .column       (column),
        .row          (row),
        .last_of_item (last_of_item),
        .image_done   (image_done),
        .truncated    (truncated),
        .pos_col      (pos_col),
        .pos_row      (pos_row),
        .flags        (flags),
        .cmd          (cmd)
    );

endmodule

// ----- sim/pcx_rle_decoder_tb.sv -----
// Testbench for the PCX run-length decoder: directed and random byte streams checked word by word.
`timescale 1ns / 1ps

module pcx_rle_decoder_tb;

    import pcx_pkg::*;

    localparam logic [ADDR_W-1:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
    localparam logic [ADDR_W-1:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};
    localparam int QUIET_CYCLES = 24;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        logic              last_of_item;
        logic              image_done;
        logic              truncated;
    } pix_word_t;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              byte_valid  = 1'b0;
    logic              byte_stall;
    logic [BYTE_W-1:0] data_byte   = '0;
    logic              end_of_data = 1'b0;
    logic              pix_valid;
    logic              pix_stall   = 1'b0;
    logic [BYTE_W-1:0] pixel;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              last_of_item;
    logic              image_done;
    logic              truncated;

    pix_word_t expected_pixels[$];
    int        mismatch_count  = 0;
    int        src_idle_pct    = 0;
    int        sink_idle_pct   = 0;
    int        hold_off_cycles = 0;

    logic [CFG_W-1:0] cfg_width       = 1;
    logic [CFG_W-1:0] cfg_height      = 1;
    logic             dec_await_value = 1'b0;
    logic [CNT_W-1:0] dec_run_len     = '0;
    logic [CFG_W-1:0] dec_col         = '0;
    logic [CFG_W-1:0] dec_row         = '0;
    logic             dec_complete    = 1'b0;

    pcx_rle_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_data  (end_of_data),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pixel        (pixel),
        .column       (column),
        .row          (row),
        .last_of_item (last_of_item),
        .image_done   (image_done),
        .truncated    (truncated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return CFG_W'(1);
        if (v > DEFAULT_MAX_DIMENSION)
            return CFG_W'(DEFAULT_MAX_DIMENSION);
        return v;
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic eod);
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int               count;
        bit               have_value;
        pix_word_t        word;
        pix_word_t        words[$];
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        count = 0;
        have_value = 1'b0;
        if (!dec_complete && dec_row >= h)
            dec_complete = 1'b1;
        if (!dec_complete)
        begin
            if (dec_await_value)
            begin
                count = dec_run_len;
                dec_await_value = 1'b0;
                dec_run_len = '0;
                have_value = 1'b1;
            end
            else if (b[BYTE_W-1 -: 2] == RUN_TAG)
            begin
                dec_run_len = b[CNT_W-1:0];
                dec_await_value = 1'b1;
            end
            else
            begin
                count = 1;
                have_value = 1'b1;
            end
            if (have_value)
            begin
                for (int i = 0; i < count; i++)
                begin
                    if (dec_col < w)
                    begin
                        word = '0;
                        word.pixel = b;
                        word.column = dec_col[POS_W-1:0];
                        word.row = dec_row[POS_W-1:0];
                        words.push_back(word);
                        dec_col++;
                    end
                end
                if (dec_col >= w)
                begin
                    dec_col = '0;
                    dec_row++;
                    if (dec_row >= h)
                    begin
                        dec_complete = 1'b1;
                        if (words.size() > 0)
                        begin
                            word = words.pop_back();
                            word.image_done = 1'b1;
                            words.push_back(word);
                        end
                    end
                end
            end
        end
        if (eod)
        begin
            if (!dec_complete)
            begin
                word = '0;
                word.column = dec_col[POS_W-1:0];
                word.row = dec_row[POS_W-1:0];
                word.truncated = 1'b1;
                words.push_back(word);
            end
            dec_await_value = 1'b0;
            dec_run_len = '0;
            dec_col = '0;
            dec_row = '0;
            dec_complete = 1'b0;
        end
        if (words.size() > 0)
        begin
            word = words.pop_back();
            word.last_of_item = 1'b1;
            words.push_back(word);
        end
        foreach (words[k])
            expected_pixels.push_back(words[k]);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_stream_byte();
        logic [BYTE_W-1:0] v;
        logic [CNT_W-1:0]  run;
        if (dec_await_value)
        begin
            v = BYTE_W'($urandom_range(255));
            return v;
        end
        if ($urandom_range(99) < 40)
        begin
            run = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(63))
                                           : CNT_W'($urandom_range(4));
            v = {RUN_TAG, run};
            return v;
        end
        v = BYTE_W'($urandom_range(191));
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_extreme_dim();
        case ($urandom_range(3))
            0: return '0;
            1: return CFG_W'(DEFAULT_MAX_DIMENSION);
            2: return {CFG_W{1'b1}};
            default: return CFG_W'(DEFAULT_MAX_DIMENSION + 1);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] v);
        logic [DATA_W-1:0] data;
        data = '0;
        if ($urandom_range(3) == 0)
            data = $urandom;
        data[CFG_W-1:0] = v;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == WIDTH_ADDR)
            cfg_width = v;
        else
            cfg_height = v;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eod);
        if ($urandom_range(99) < src_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        decode_byte(b, eod);
        byte_valid <= 1'b1;
        data_byte <= b;
        end_of_data <= eod;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic test_literals_and_runs();
        wait_idle();
        write_reg(WIDTH_ADDR, 4);
        write_reg(HEIGHT_ADDR, 2);
        send_byte(8'h00, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        // An empty run consumes its value byte without output.
        send_byte(8'hC0, 1'b0);
        send_byte(8'hFF, 1'b0);
        // This run overflows the row and completes the image.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC1, 1'b1);
    endtask

    task automatic test_truncation();
        wait_idle();
        send_byte(8'hC5, 1'b1);
        send_byte(8'h33, 1'b1);
    endtask

    task automatic test_dimension_change();
        wait_idle();
        write_reg(WIDTH_ADDR, 8);
        write_reg(HEIGHT_ADDR, 3);
        send_byte(8'hC6, 1'b0);
        send_byte(8'h21, 1'b0);
        wait_idle();
        write_reg(WIDTH_ADDR, 4);
        send_byte(8'h09, 1'b0);
        wait_idle();
        write_reg(HEIGHT_ADDR, 1);
        send_byte(8'h44, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(WIDTH_ADDR, 0);
        write_reg(HEIGHT_ADDR, 0);
        send_byte(8'h9A, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
        write_reg(WIDTH_ADDR, {CFG_W{1'b1}});
        write_reg(HEIGHT_ADDR, {CFG_W{1'b1}});
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(WIDTH_ADDR, CFG_W'(DEFAULT_MAX_DIMENSION));
        write_reg(HEIGHT_ADDR, 2);
        hold_off_cycles = HOLD_CYCLES;
        send_byte(8'hFF, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h11, 1'b1);
    endtask

    task automatic test_random_images(input int n_items);
        int               counted;
        int               kind;
        int               budget;
        int               extra;
        int               area;
        bit               extreme;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        counted = 0;
        while (counted < n_items)
        begin
            wait_idle();
            extreme = ($urandom_range(99) < 6);
            if (extreme)
            begin
                w = pick_extreme_dim();
                h = pick_extreme_dim();
            end
            else
            begin
                w = CFG_W'($urandom_range(12, 1));
                h = CFG_W'($urandom_range(6, 1));
            end
            if (extreme || $urandom_range(9) != 0)
            begin
                write_reg(WIDTH_ADDR, w);
                write_reg(HEIGHT_ADDR, h);
            end
            area = clamp_dim(cfg_width);
            area = area * clamp_dim(cfg_height);
            kind = $urandom_range(99);
            if (kind < 70 && area <= 200)
            begin
                budget = 0;
                while (!dec_complete && budget < 600)
                begin
                    send_byte(pick_stream_byte(), 1'b0);
                    budget++;
                end
                extra = $urandom_range(3);
                repeat (extra) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
                send_byte(BYTE_W'($urandom_range(255)), 1'b1);
                counted += budget + extra + 1;
            end
            else if (kind < 90 || area > 200)
            begin
                budget = $urandom_range(8, 1);
                repeat (budget - 1) send_byte(pick_stream_byte(), 1'b0);
                send_byte(pick_stream_byte(), 1'b1);
                counted += budget;
            end
            else
            begin
                budget = $urandom_range(10, 1);
                repeat (budget) send_byte(BYTE_W'($urandom_range(255)),
                                          $urandom_range(4) == 0);
                send_byte(BYTE_W'($urandom_range(255)), 1'b1);
                counted += budget + 1;
            end
        end
    endtask

    initial
    begin : check_pixels
        pix_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_valid && !pix_stall)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("unexpected word pixel %0d column %0d row %0d",
                                              pixel, column, row));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel !== want.pixel)
                        report_mismatch($sformatf("pixel %0d, want %0d", pixel, want.pixel));
                    if (column !== want.column)
                        report_mismatch($sformatf("column %0d, want %0d", column, want.column));
                    if (row !== want.row)
                        report_mismatch($sformatf("row %0d, want %0d", row, want.row));
                    if (last_of_item !== want.last_of_item)
                        report_mismatch($sformatf("last_of_item %0b, want %0b",
                                                  last_of_item, want.last_of_item));
                    if (image_done !== want.image_done)
                        report_mismatch($sformatf("image_done %0b, want %0b",
                                                  image_done, want.image_done));
                    if (truncated !== want.truncated)
                        report_mismatch($sformatf("truncated %0b, want %0b",
                                                  truncated, want.truncated));
                end
            end
        end
    end

    initial
    begin : drive_pix_stall
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                pix_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
                pix_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (pix_valid && !pix_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("pcx_rle_decoder_tb: done, errors");
        $finish;
    end

    initial
    begin : run_tests
        src_idle_pct = 12;
        sink_idle_pct = 70;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_literals_and_runs();
        test_truncation();
        test_dimension_change();
        test_register_extremes();
        test_random_images(120);
        wait_idle();
        src_idle_pct = 70;
        sink_idle_pct = 12;
        test_random_images(120);
        wait_idle();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_backpressure();
        test_random_images(120);
        wait_idle();
        if (mismatch_count == 0)
            $display("pcx_rle_decoder_tb: done, clean");
        else
            $display("pcx_rle_decoder_tb: done, errors");
        $finish;
    end

endmodule
